/* rtl/assert_macros.svh */
// Assertion helpers shared by the speed controller modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, ck, rn, ante, cons)
`define ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

/* rtl/hsp_pkg.sv */
package hsp_pkg;

	// Default fixed-point formats.
	localparam int FREQ_FRAC_BITS = 8;
	localparam int GAIN_FRAC_BITS = 16;

	// Field widths.
	localparam int FREQ_W  = 16;
	localparam int GAIN_W  = 24;
	localparam int TIME_W  = 32;
	localparam int LEVEL_W = 10;
	localparam int MINI_W  = 20;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// Register reset values.
	localparam logic [GAIN_W-1:0]  GAIN_P_RST = 24'd6553600;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST = 24'd655;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST = 24'd3276800;
	localparam logic [MINI_W-1:0]  MIN_INT_RST = 20'd5000;
	localparam logic [LEVEL_W-1:0] LEVEL_THR_RST = 10'd30;
	localparam logic [FREQ_W-1:0]  MAX_STEP_RST = 16'd5120;

	// Register indexes.
	typedef enum logic [2:0] {
		REG_TARGET   = 3'd0,
		REG_ENABLE   = 3'd1,
		REG_GAIN_P   = 3'd2,
		REG_GAIN_I   = 3'd3,
		REG_GAIN_D   = 3'd4,
		REG_MIN_INT  = 3'd5,
		REG_LEVEL    = 3'd6,
		REG_MAX_STEP = 3'd7
	} reg_idx_t;

	// Configuration as seen by the control logic.
	typedef struct packed {
		logic [FREQ_W-1:0]  target_freq;
		logic               control_enable;
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [MINI_W-1:0]  min_interval_us;
		logic [LEVEL_W-1:0] level_threshold;
		logic [FREQ_W-1:0]  max_step;
	} cfg_t;

	function automatic int maxi(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

/* rtl/hsp_regs.sv */
module hsp_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hsp_pkg::ADDR_W-1:0]    paddr,
	input  logic [hsp_pkg::DATA_W-1:0]    pwdata,
	output logic [hsp_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output hsp_pkg::cfg_t                 cfg
);

	hsp_pkg::cfg_t    cfg_q;
	hsp_pkg::reg_idx_t idx;

	assign idx    = hsp_pkg::reg_idx_t'(paddr[hsp_pkg::ADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_freq     <= '0;
			cfg_q.control_enable  <= 1'b0;
			cfg_q.gain_p          <= hsp_pkg::GAIN_P_RST;
			cfg_q.gain_i          <= hsp_pkg::GAIN_I_RST;
			cfg_q.gain_d          <= hsp_pkg::GAIN_D_RST;
			cfg_q.min_interval_us <= hsp_pkg::MIN_INT_RST;
			cfg_q.level_threshold <= hsp_pkg::LEVEL_THR_RST;
			cfg_q.max_step        <= hsp_pkg::MAX_STEP_RST;
		end else if (psel && penable && pwrite) begin
			case (idx)
				hsp_pkg::REG_TARGET: begin
					cfg_q.target_freq <= pwdata[hsp_pkg::FREQ_W-1:0];
				end
				hsp_pkg::REG_ENABLE: begin
					cfg_q.control_enable <= pwdata[0];
				end
				hsp_pkg::REG_GAIN_P: begin
					cfg_q.gain_p <= pwdata[hsp_pkg::GAIN_W-1:0];
				end
				hsp_pkg::REG_GAIN_I: begin
					cfg_q.gain_i <= pwdata[hsp_pkg::GAIN_W-1:0];
				end
				hsp_pkg::REG_GAIN_D: begin
					cfg_q.gain_d <= pwdata[hsp_pkg::GAIN_W-1:0];
				end
				hsp_pkg::REG_MIN_INT: begin
					cfg_q.min_interval_us <= pwdata[hsp_pkg::MINI_W-1:0];
				end
				hsp_pkg::REG_LEVEL: begin
					cfg_q.level_threshold <= pwdata[hsp_pkg::LEVEL_W-1:0];
				end
				hsp_pkg::REG_MAX_STEP: begin
					cfg_q.max_step <= pwdata[hsp_pkg::FREQ_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read mux.
	always_comb begin
		case (idx)
			hsp_pkg::REG_TARGET:   prdata = hsp_pkg::DATA_W'(cfg_q.target_freq);
			hsp_pkg::REG_ENABLE:   prdata = hsp_pkg::DATA_W'(cfg_q.control_enable);
			hsp_pkg::REG_GAIN_P:   prdata = hsp_pkg::DATA_W'(cfg_q.gain_p);
			hsp_pkg::REG_GAIN_I:   prdata = hsp_pkg::DATA_W'(cfg_q.gain_i);
			hsp_pkg::REG_GAIN_D:   prdata = hsp_pkg::DATA_W'(cfg_q.gain_d);
			hsp_pkg::REG_MIN_INT:  prdata = hsp_pkg::DATA_W'(cfg_q.min_interval_us);
			hsp_pkg::REG_LEVEL:    prdata = hsp_pkg::DATA_W'(cfg_q.level_threshold);
			hsp_pkg::REG_MAX_STEP: prdata = hsp_pkg::DATA_W'(cfg_q.max_step);
			default:               prdata = '0;
		endcase
	end

endmodule

/* rtl/hsp_div.sv */
`include "assert_macros.svh"
module hsp_div #(
	parameter int NUM_W = 28,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic [NUM_W-1:0] work_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// One restoring step: bring in the next numerator bit and try to subtract.
	assign trial = {rem_q, work_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quot  = work_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			work_q <= '0;
			den_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				work_q <= num;
				den_q  <= den;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				work_q <= {work_q[NUM_W-2:0], ge};
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	`ASSERT_IMPLIES(a_div_start_free, clk, arst_n, start, !busy_q)
	`ASSERT_NEXT(a_div_done_ends, clk, arst_n, done_q, !done_q)

endmodule

/* rtl/hsp_mul.sv */
`include "assert_macros.svh"
module hsp_mul #(
	parameter int A_W = 40,
	parameter int B_W = 32,
	parameter int P_W = 47
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [A_W-1:0] a,
	input  logic [B_W-1:0] b,
	input  logic [P_W-1:0] limit,
	output logic           done,
	output logic [P_W-1:0] prod,
	output logic           sat
);

	localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

	logic [A_W-1:0] a_q;
	logic [B_W-1:0] b_q;
	logic [P_W-1:0] lim_q;
	logic [P_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic           sat_q;
	logic [P_W-1:0] acc_next;

	// Shift-add, multiplier bits taken most significant first.
	assign acc_next = {acc_q[P_W-2:0], 1'b0} + (b_q[B_W-1] ? P_W'(a_q) : '0);
	assign done = done_q;
	assign prod = acc_q;
	assign sat  = sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			lim_q  <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= a;
				b_q    <= b;
				lim_q  <= limit;
				acc_q  <= '0;
				sat_q  <= 1'b0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// Once past the limit the product only grows, so it stays saturated.
				if (!sat_q) begin
					acc_q <= acc_next;
					if (acc_next > lim_q) begin
						sat_q <= 1'b1;
					end
				end
				b_q   <= {b_q[B_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	`ASSERT_IMPLIES(a_mul_start_free, clk, arst_n, start, !busy_q)
	`ASSERT_IMPLIES(a_mul_in_limit, clk, arst_n, busy_q && !sat_q, acc_q <= lim_q)

endmodule

/* rtl/hall_pulse_speed_pid.sv */
// Hall pulse speed controller.
// Each input beat is one falling edge of the Hall sensor: its microsecond
// time, its millisecond time and the analog level. Each input beat gives
// exactly one output beat: whether the edge was accepted, the latest
// frequency, the two-sample average and the drive level.
// A rejected edge or the first edge goes from the idle state straight to
// the output state. A measuring edge first runs one serial division for
// its frequency. With control enabled, the PID step adds four serial
// multiplies, up to two more divisions and the set-up, selection and sum
// steps. The divider and multiplier are shared and bit-serial, and one
// edge is worked on at a time.
// A finished result waits in the output register, so the next edge can be
// taken while the receiver stalls; that edge then holds at the end of its
// work until the output register frees.
// Reset returns the registers and the controller state to their defaults,
// with the drive at 170.0. The user must write configuration over the APB
// port only while no edge is in work; the block does not enforce this.
`include "assert_macros.svh"
module hall_pulse_speed_pid #(
	parameter int FREQ_FRAC_BITS = hsp_pkg::FREQ_FRAC_BITS,
	parameter int GAIN_FRAC_BITS = hsp_pkg::GAIN_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hsp_pkg::ADDR_W-1:0]    paddr,
	input  logic [hsp_pkg::DATA_W-1:0]    pwdata,
	output logic [hsp_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [hsp_pkg::TIME_W-1:0]    pulse_time_us,
	input  logic [hsp_pkg::TIME_W-1:0]    now_ms,
	input  logic [hsp_pkg::LEVEL_W-1:0]   sensor_level,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          pulse_accepted,
	output logic [hsp_pkg::FREQ_W-1:0]    measured_freq,
	output logic [hsp_pkg::FREQ_W-1:0]    average_freq,
	output logic [hsp_pkg::FREQ_W-1:0]    drive_level
);

	localparam int F  = FREQ_FRAC_BITS;
	localparam int G  = GAIN_FRAC_BITS;
	localparam int FW = hsp_pkg::FREQ_W;
	localparam int TW = hsp_pkg::TIME_W;
	localparam int GW = hsp_pkg::GAIN_W;

	// Datapath widths.
	localparam int NUM_W = hsp_pkg::maxi(20 + F, 27);
	localparam int A_W   = hsp_pkg::maxi(FW + GW, F + 7);
	localparam int MP_W  = hsp_pkg::maxi(hsp_pkg::maxi(G + 29, 41), F + 31);
	localparam int SUM_W = MP_W + 2;
	localparam int INT_W = hsp_pkg::maxi(F + 9, 18) + 2;
	localparam int DRV_W = F + 8;

	// Constants in the fixed-point formats above.
	localparam logic [NUM_W-1:0] FREQ_NUM = NUM_W'(64'd1000000 << F);
	localparam logic [MP_W-1:0]  CAP = MP_W'(64'd131072000 << G);
	localparam logic [NUM_W-1:0] LIM_D = NUM_W'(100 << F);
	localparam logic signed [INT_W-1:0] LIM_I = INT_W'(255 << F);
	localparam logic [INT_W-1:0] SAT_MAG = INT_W'(64'd2 << (F + 8));
	localparam logic signed [SUM_W-1:0] TOP_S = SUM_W'(255 << F);
	localparam logic [DRV_W-1:0] DRIVE_RST = DRV_W'(170 << F);
	localparam logic [TW-1:0]    DT_ZERO = TW'(10);
	localparam logic [TW-1:0]    DT_MIN = TW'(2);
	localparam logic [TW-1:0]    MS_PER_S = TW'(1000);

	typedef enum logic [3:0] {
		S_IDLE, S_FREQ, S_PGO, S_P, S_M, S_MDT, S_IDIV, S_DSEL, S_DDIV, S_D, S_SUM,
		S_OUT
	} state_t;

	hsp_pkg::cfg_t cfg;
	state_t        state_q;

	// Controller state.
	logic [TW-1:0]  last_us_q;
	logic           seen_q;
	logic [FW-1:0]  prev_freq_q;
	logic           pair_q;
	logic [FW-1:0]  avg_q;
	logic signed [FW:0] prev_err_q;
	logic signed [INT_W-1:0] int_q;
	logic [DRV_W-1:0] drive_q;
	logic [TW-1:0]  last_ctl_q;

	// Per-edge work registers.
	logic [TW-1:0]  t_ms_q;
	logic           acc_ok_q;
	logic signed [FW:0] err_q;
	logic [TW-1:0]  dt_q;
	logic signed [SUM_W-1:0] p_q;
	logic signed [SUM_W-1:0] d_q;

	// Serial unit operands.
	logic           div_start_q;
	logic [NUM_W-1:0] div_num_q;
	logic [TW-1:0]  div_den_q;
	logic           div_done;
	logic [NUM_W-1:0] div_quot;
	logic           mul_start_q;
	logic [A_W-1:0] mul_a_q;
	logic [TW-1:0]  mul_b_q;
	logic [MP_W-1:0] mul_lim_q;
	logic           mul_done;
	logic [MP_W-1:0] mul_prod;
	logic           mul_sat;

	// Output register.
	logic           out_valid_q;
	logic           out_acc_q;
	logic [FW-1:0]  out_freq_q;
	logic [FW-1:0]  out_avg_q;
	logic [FW-1:0]  out_drive_q;

	// Combinational helpers.
	logic [TW-1:0]  interval_c;
	logic           ok_c;
	logic [FW-1:0]  f_c;
	logic [FW:0]    avg_sum_c;
	logic [FW-1:0]  avg_next_c;
	logic signed [FW:0] err_c;
	logic [FW:0]    err_neg_c;
	logic [FW-1:0]  err_abs_c;
	logic [TW-1:0]  dt_raw_c;
	logic [TW-1:0]  dt_c;
	logic signed [FW+1:0] diff_c;
	logic [FW+1:0]  diff_neg_c;
	logic [FW:0]    diff_abs_c;
	logic [26:0]    dmul_c;
	logic [NUM_W-1:0] deriv_c;
	logic signed [SUM_W-1:0] sum_c;
	logic signed [SUM_W-1:0] next_c;
	logic signed [SUM_W-1:0] drv_s_c;
	logic signed [SUM_W-1:0] step_c;
	logic signed [SUM_W-1:0] slew_c;

	hsp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hsp_div #(
		.NUM_W (NUM_W),
		.DEN_W (TW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	hsp_mul #(
		.A_W (A_W),
		.B_W (TW),
		.P_W (MP_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.limit  (mul_lim_q),
		.done   (mul_done),
		.prod   (mul_prod),
		.sat    (mul_sat)
	);

	// Gain product scaled down, rounded toward minus infinity.
	function automatic logic signed [SUM_W-1:0] fshift(input logic [MP_W-1:0] x,
			input logic neg);
		logic [SUM_W-1:0] xe;
		xe = SUM_W'(x);
		if (neg && (x != '0)) begin
			return $signed(~((xe - SUM_W'(1)) >> G));
		end
		return $signed(xe >> G);
	endfunction

	// Integral step applied with sign, then clamped.
	function automatic logic signed [INT_W-1:0] int_upd(
			input logic signed [INT_W-1:0] cur, input logic [INT_W-1:0] mag,
			input logic neg);
		logic signed [INT_W-1:0] s;
		s = neg ? (cur - $signed(mag)) : (cur + $signed(mag));
		if (s > LIM_I) begin
			return LIM_I;
		end
		if (s < -LIM_I) begin
			return -LIM_I;
		end
		return s;
	endfunction

	// Edge checks on the incoming beat.
	assign interval_c = pulse_time_us - last_us_q;
	assign ok_c = (sensor_level < cfg.level_threshold) &&
		!(seen_q && (interval_c <= TW'(cfg.min_interval_us)));

	// Frequency, average and error once the division finishes.
	always_comb begin
		f_c = (|div_quot[NUM_W-1:FW]) ? '1 : div_quot[FW-1:0];
		avg_sum_c = {1'b0, prev_freq_q} + {1'b0, f_c};
		avg_next_c = pair_q ? avg_sum_c[FW:1] : avg_q;
		err_c = $signed({1'b0, cfg.target_freq}) - $signed({1'b0, avg_next_c});
		dt_raw_c = t_ms_q - last_ctl_q;
		dt_c = (dt_raw_c == '0) ? DT_ZERO : dt_raw_c;
	end

	// Magnitudes for the serial units.
	always_comb begin
		err_neg_c = -err_q;
		err_abs_c = err_q[FW] ? err_neg_c[FW-1:0] : err_q[FW-1:0];
		diff_c = {err_q[FW], err_q} - {prev_err_q[FW], prev_err_q};
		diff_neg_c = -diff_c;
		diff_abs_c = diff_c[FW+1] ? diff_neg_c[FW:0] : diff_c[FW:0];
		dmul_c = (27'(diff_abs_c) << 10) - (27'(diff_abs_c) << 4) -
			(27'(diff_abs_c) << 3);
		deriv_c = (div_quot > LIM_D) ? LIM_D : div_quot;
	end

	// Drive sum, clamp and slew.
	always_comb begin
		drv_s_c = $signed(SUM_W'(drive_q));
		step_c = $signed(SUM_W'(cfg.max_step));
		sum_c = drv_s_c + p_q + SUM_W'(int_q) + d_q;
		if (sum_c < 0) begin
			next_c = '0;
		end else if (sum_c > TOP_S) begin
			next_c = TOP_S;
		end else begin
			next_c = sum_c;
		end
		if ((next_c - drv_s_c) > step_c) begin
			slew_c = drv_s_c + step_c;
		end else if ((drv_s_c - next_c) > step_c) begin
			slew_c = drv_s_c - step_c;
		end else begin
			slew_c = next_c;
		end
	end

	// Sequencer over the shared divider and multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_us_q   <= '0;
			seen_q      <= 1'b0;
			prev_freq_q <= '0;
			pair_q      <= 1'b0;
			avg_q       <= '0;
			prev_err_q  <= '0;
			int_q       <= '0;
			drive_q     <= DRIVE_RST;
			last_ctl_q  <= '0;
			t_ms_q      <= '0;
			acc_ok_q    <= 1'b0;
			err_q       <= '0;
			dt_q        <= '0;
			p_q         <= '0;
			d_q         <= '0;
			div_start_q <= 1'b0;
			div_num_q   <= '0;
			div_den_q   <= '0;
			mul_start_q <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			mul_lim_q   <= '0;
			out_valid_q <= 1'b0;
			out_acc_q   <= 1'b0;
			out_freq_q  <= '0;
			out_avg_q   <= '0;
			out_drive_q <= '0;
		end else begin
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						t_ms_q   <= now_ms;
						acc_ok_q <= ok_c;
						if (ok_c) begin
							seen_q    <= 1'b1;
							last_us_q <= pulse_time_us;
						end
						if (ok_c && seen_q && (interval_c != '0)) begin
							div_num_q   <= FREQ_NUM;
							div_den_q   <= interval_c;
							div_start_q <= 1'b1;
							state_q     <= S_FREQ;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_FREQ: begin
					if (div_done) begin
						prev_freq_q <= f_c;
						avg_q       <= avg_next_c;
						pair_q      <= !pair_q;
						if (cfg.control_enable && (cfg.target_freq != '0)) begin
							err_q       <= err_c;
							dt_q        <= dt_c;
							state_q     <= S_PGO;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_PGO: begin
					// Proportional product; the error settled in the cycle before.
					mul_a_q     <= A_W'(err_abs_c);
					mul_b_q     <= TW'(cfg.gain_p);
					mul_lim_q   <= '1;
					mul_start_q <= 1'b1;
					state_q     <= S_P;
				end
				S_P: begin
					if (mul_done) begin
						p_q         <= fshift(mul_prod, err_q[FW]);
						mul_a_q     <= A_W'(err_abs_c);
						mul_b_q     <= TW'(cfg.gain_i);
						mul_start_q <= 1'b1;
						state_q     <= S_M;
					end
				end
				S_M: begin
					if (mul_done) begin
						mul_a_q     <= A_W'(mul_prod);
						mul_b_q     <= dt_q;
						mul_lim_q   <= CAP;
						mul_start_q <= 1'b1;
						state_q     <= S_MDT;
					end
				end
				S_MDT: begin
					if (mul_done) begin
						if (mul_sat) begin
							int_q   <= int_upd(int_q, SAT_MAG, err_q[FW]);
							state_q <= S_DSEL;
						end else begin
							div_num_q   <= NUM_W'(mul_prod >> G);
							div_den_q   <= MS_PER_S;
							div_start_q <= 1'b1;
							state_q     <= S_IDIV;
						end
					end
				end
				S_IDIV: begin
					if (div_done) begin
						int_q   <= int_upd(int_q, INT_W'(div_quot), err_q[FW]);
						state_q <= S_DSEL;
					end
				end
				S_DSEL: begin
					if (dt_q >= DT_MIN) begin
						div_num_q   <= NUM_W'(dmul_c);
						div_den_q   <= dt_q;
						div_start_q <= 1'b1;
						state_q     <= S_DDIV;
					end else begin
						d_q     <= '0;
						state_q <= S_SUM;
					end
				end
				S_DDIV: begin
					if (div_done) begin
						mul_a_q     <= A_W'(deriv_c);
						mul_b_q     <= TW'(cfg.gain_d);
						mul_lim_q   <= '1;
						mul_start_q <= 1'b1;
						state_q     <= S_D;
					end
				end
				S_D: begin
					if (mul_done) begin
						d_q     <= fshift(mul_prod, diff_c[FW+1]);
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					drive_q    <= DRV_W'(slew_c);
					prev_err_q <= err_q;
					last_ctl_q <= t_ms_q;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_acc_q   <= acc_ok_q;
						out_freq_q  <= prev_freq_q;
						out_avg_q   <= avg_q;
						out_drive_q <= FW'(drive_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign pulse_accepted = out_acc_q;
	assign measured_freq  = out_freq_q;
	assign average_freq   = out_avg_q;
	assign drive_level    = out_drive_q;

	`ASSERT_NEXT(a_one_edge_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)
	`ASSERT_IMPLIES(a_drive_in_range, clk, arst_n, 1'b1, $signed(SUM_W'(drive_q)) <= TOP_S)
	`ASSERT_IMPLIES(a_integral_in_range, clk, arst_n, 1'b1, (int_q <= LIM_I) && (int_q >= -LIM_I))

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int F = 8;
	localparam int G = 16;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct {
		bit        accepted;
		bit [15:0] freq;
		bit [15:0] avg;
		bit [15:0] drive;
	} speed_result_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [hsp_pkg::ADDR_W-1:0] paddr;
	logic [hsp_pkg::DATA_W-1:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [hsp_pkg::TIME_W-1:0] pulse_time_us, now_ms;
	logic [hsp_pkg::LEVEL_W-1:0] sensor_level;
	logic pulse_accepted;
	logic [hsp_pkg::FREQ_W-1:0] measured_freq, average_freq, drive_level;

	hall_pulse_speed_pid DUT (.*);

	// Configuration and controller state as the predictor sees them.
	hsp_pkg::cfg_t cfg;
	bit [31:0] last_us, last_ms;
	bit        seen;
	bit [15:0] prev_freq, avg_freq;
	bit        pair;
	longint    prev_err, integ, drive;

	speed_result_t expected_q[$];
	int  errors = 0;
	int  tx_idle_pct = 0, rx_idle_pct = 0, hold_cycles = 0;
	longint cycles = 0;
	bit [31:0] t_us, t_ms;

	// Clock.
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off while the hold count runs down.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		speed_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat acc=%0d freq=%0d", $time,
					pulse_accepted, measured_freq);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (pulse_accepted !== e.accepted || measured_freq !== e.freq ||
					average_freq !== e.avg || drive_level !== e.drive) begin
					$display("%0t: mismatch exp acc=%0d freq=%0d avg=%0d drive=%0d",
						$time, e.accepted, e.freq, e.avg, e.drive);
					$display("%0t:          got acc=%0d freq=%0d avg=%0d drive=%0d",
						$time, pulse_accepted, measured_freq, average_freq, drive_level);
					errors++;
				end
			end
		end
	end

	function automatic longint clampl(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// One PID update of the drive.
	function automatic void pid_update(bit [31:0] ms);
		longint unsigned dt, m, cap, mag, q;
		longint err, p, d, deriv, diff, nxt, step;
		dt = longint'(ms - last_ms);
		if (dt == 0) dt = 10;
		err = longint'(cfg.target_freq) - longint'(avg_freq);
		p = (longint'(cfg.gain_p) * err) >>> G;
		m = longint'(err < 0 ? -err : err) * longint'(cfg.gain_i);
		cap = 64'd131072000 << G;
		if (m > cap / dt)
			mag = 64'd2 << (F + 8);
		else
			mag = (m * dt) / (64'd1000 << G);
		integ = integ + ((err < 0) ? -longint'(mag) : longint'(mag));
		integ = clampl(integ, -(255 <<< F), 255 <<< F);
		deriv = 0;
		if (dt >= 2) begin
			diff = err - prev_err;
			q = (longint'(diff < 0 ? -diff : diff) * 1000) / dt;
			deriv = (diff < 0) ? -longint'(q) : longint'(q);
			deriv = clampl(deriv, -(100 <<< F), 100 <<< F);
		end
		d = (longint'(cfg.gain_d) * deriv) >>> G;
		nxt = clampl(drive + p + integ + d, 0, 255 <<< F);
		step = longint'(cfg.max_step);
		if (nxt - drive > step) nxt = drive + step;
		else if (drive - nxt > step) nxt = drive - step;
		drive = nxt;
		prev_err = err;
		last_ms = ms;
	endfunction

	// Expected result of one Hall edge; updates the predicted state.
	function automatic speed_result_t predict_edge(bit [31:0] us, bit [31:0] ms,
		bit [9:0] level);
		speed_result_t r;
		bit [31:0] interval;
		longint unsigned f;
		bit ok;
		interval = us - last_us;
		ok = level < cfg.level_threshold;
		if (seen && interval <= cfg.min_interval_us) ok = 0;
		if (ok) begin
			if (seen && interval != 0) begin
				f = (64'd1000000 << F) / interval;
				if (f > 16'hFFFF) f = 16'hFFFF;
				if (pair) begin
					avg_freq = (longint'(prev_freq) + f) >> 1;
					pair = 0;
				end else begin
					pair = 1;
				end
				prev_freq = f;
				if (cfg.control_enable && cfg.target_freq != 0) pid_update(ms);
			end
			seen = 1;
			last_us = us;
		end
		r.accepted = ok;
		r.freq = prev_freq;
		r.avg = avg_freq;
		r.drive = drive[15:0];
		return r;
	endfunction

	// Send one edge beat and record its expected result.
	task automatic send_edge(bit [31:0] us, bit [31:0] ms, bit [9:0] level);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		pulse_time_us <= us;
		now_ms <= ms;
		sensor_level <= level;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(predict_edge(us, ms, level));
		if ($urandom_range(99) < tx_idle_pct) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// APB write; the predictor copy changes with it.
	task automatic write_reg(hsp_pkg::reg_idx_t idx, bit [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			hsp_pkg::REG_TARGET:   cfg.target_freq = value[15:0];
			hsp_pkg::REG_ENABLE:   cfg.control_enable = value[0];
			hsp_pkg::REG_GAIN_P:   cfg.gain_p = value[23:0];
			hsp_pkg::REG_GAIN_I:   cfg.gain_i = value[23:0];
			hsp_pkg::REG_GAIN_D:   cfg.gain_d = value[23:0];
			hsp_pkg::REG_MIN_INT:  cfg.min_interval_us = value[19:0];
			hsp_pkg::REG_LEVEL:    cfg.level_threshold = value[9:0];
			hsp_pkg::REG_MAX_STEP: cfg.max_step = value[15:0];
			default: ;
		endcase
	endtask

	// Next edge time after the given interval from the last accepted edge.
	task automatic edge_after(bit [31:0] interval, bit [31:0] dms, bit [9:0] level);
		t_us = last_us + interval;
		t_ms = t_ms + dms;
		send_edge(t_us, t_ms, level);
	endtask

	task automatic test_defaults_and_edges();
		// First edge with the level too high, then the first good edge.
		send_edge(32'd1000, 32'd0, 10'd1023);
		send_edge(32'd1000, 32'd0, 10'd0);
		// Bounce at exactly the minimum interval, then just above it.
		edge_after(32'd5000, 0, 10'd0);
		edge_after(32'd5001, 5, 10'd29);
		edge_after(32'd10000, 10, 10'd30);
		edge_after(32'd10000, 10, 10'd5);
	endtask

	task automatic test_control_directed();
		wait_idle();
		write_reg(hsp_pkg::REG_TARGET, 32'd12800);
		write_reg(hsp_pkg::REG_ENABLE, 32'd1);
		// Zero dt, one ms, long dt, and wrapping time stamps.
		edge_after(32'd20000, 0, 10'd1);
		edge_after(32'd20000, 0, 10'd1);
		edge_after(32'd15000, 1, 10'd1);
		edge_after(32'd8000, 2, 10'd1);
		edge_after(32'd100000, 5000, 10'd1);
		t_ms = 32'hFFFF_FFF0;
		edge_after(32'd20000, 0, 10'd1);
		edge_after(32'd20000, 32'h20, 10'd1);
		t_us = 32'hFFFF_F000;
		send_edge(t_us, t_ms, 10'd2);
		edge_after(32'd9000, 9, 10'd2);
		edge_after(32'd9000, 9, 10'd2);
		// Saturated frequency with no minimum interval.
		wait_idle();
		write_reg(hsp_pkg::REG_MIN_INT, 32'd0);
		write_reg(hsp_pkg::REG_MAX_STEP, 32'd0);
		edge_after(32'd1, 3, 10'd0);
		edge_after(32'd3, 3, 10'd0);
		edge_after(32'd0, 3, 10'd0);
		wait_idle();
		write_reg(hsp_pkg::REG_MAX_STEP, 32'd65535);
		write_reg(hsp_pkg::REG_GAIN_P, 32'hFFFFFF);
		write_reg(hsp_pkg::REG_GAIN_I, 32'hFFFFFF);
		write_reg(hsp_pkg::REG_GAIN_D, 32'hFFFFFF);
		write_reg(hsp_pkg::REG_TARGET, 32'd65535);
		edge_after(32'd7, 1, 10'd0);
		edge_after(32'hFFFF_FFFF, 1000, 10'd0);
		edge_after(32'd2, 3, 10'd0);
		wait_idle();
		write_reg(hsp_pkg::REG_GAIN_P, 32'd0);
		write_reg(hsp_pkg::REG_GAIN_I, 32'd0);
		write_reg(hsp_pkg::REG_GAIN_D, 32'd0);
		write_reg(hsp_pkg::REG_LEVEL, 32'd0);
		edge_after(32'd50000, 4, 10'd0);
		wait_idle();
		write_reg(hsp_pkg::REG_LEVEL, 32'd1023);
		write_reg(hsp_pkg::REG_MIN_INT, 32'hFFFFF);
		edge_after(32'hFFFFF, 4, 10'd1022);
		edge_after(32'h100000, 4, 10'd1022);
	endtask

	task automatic random_config();
		wait_idle();
		write_reg(hsp_pkg::REG_TARGET, ($urandom_range(9) == 0) ? $urandom_range(65535)
			: 256 * $urandom_range(1, 200));
		write_reg(hsp_pkg::REG_ENABLE, $urandom_range(9) != 0);
		write_reg(hsp_pkg::REG_GAIN_P,
			($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 1 << 23));
		write_reg(hsp_pkg::REG_GAIN_I,
			($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 100000));
		write_reg(hsp_pkg::REG_GAIN_D,
			($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 1 << 23));
		write_reg(hsp_pkg::REG_MIN_INT,
			($urandom_range(9) == 0) ? $urandom_range(0, 20'hFFFFF)
			: $urandom_range(0, 20000));
		write_reg(hsp_pkg::REG_LEVEL,
			($urandom_range(19) == 0) ? 0 : $urandom_range(1, 1023));
		write_reg(hsp_pkg::REG_MAX_STEP, $urandom_range(65535));
	endtask

	// Mostly well-formed edges with random content, some bounce and noise.
	task automatic random_edges(int count);
		int sel;
		bit [31:0] interval, dms;
		bit [9:0] level;
		repeat (count) begin
			sel = $urandom_range(99);
			if (sel < 78) interval = cfg.min_interval_us + $urandom_range(1, 200000);
			else if (sel < 90) interval = $urandom_range(0, cfg.min_interval_us);
			else if (sel < 95) interval = $urandom;
			else interval = $urandom_range(1, 60);
			sel = $urandom_range(99);
			if (sel < 80) dms = $urandom_range(2, 40);
			else if (sel < 90) dms = $urandom_range(0, 1);
			else dms = $urandom;
			if (cfg.level_threshold != 0 && $urandom_range(99) < 85)
				level = $urandom_range(0, cfg.level_threshold - 1);
			else
				level = $urandom_range(0, 1023);
			edge_after(interval, dms, level);
		end
	endtask

	task automatic test_random_phases();
		tx_idle_pct = 10;
		rx_idle_pct = 86;
		random_config();
		random_edges(400);
		tx_idle_pct = 86;
		rx_idle_pct = 10;
		random_config();
		random_edges(400);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_config();
		random_edges(450);
	endtask

	// Long receiver hold-off while edges keep coming, so the input stalls.
	task automatic test_output_backpressure();
		random_config();
		write_reg(hsp_pkg::REG_ENABLE, 32'd1);
		hold_cycles = 3000;
		random_edges(400);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		pulse_time_us = '0;
		now_ms = '0;
		sensor_level = '0;
		t_us = 0;
		t_ms = 0;
		cfg = '{16'd0, 1'b0, hsp_pkg::GAIN_P_RST, hsp_pkg::GAIN_I_RST,
			hsp_pkg::GAIN_D_RST, hsp_pkg::MIN_INT_RST, hsp_pkg::LEVEL_THR_RST,
			hsp_pkg::MAX_STEP_RST};
		last_us = 0;
		last_ms = 0;
		seen = 0;
		prev_freq = 0;
		avg_freq = 0;
		pair = 0;
		prev_err = 0;
		integ = 0;
		drive = 170 <<< F;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_defaults_and_edges();
		test_control_directed();
		test_random_phases();
		test_output_backpressure();

		wait_idle();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/hsp_pkg.sv
rtl/hsp_regs.sv
rtl/hsp_div.sv
rtl/hsp_mul.sv
rtl/hall_pulse_speed_pid.sv
tb/sv/testbench.sv
